/* src/edrs_pkg.sv */
// Package for the elevator disk request scheduler: payload types, codes, defaults.
// No dependencies.
`default_nettype none
package edrs_pkg;
  localparam int QueueDepthDef = 32;
  localparam int TrackBitsDef  = 10;
  localparam int OwnerBitsDef  = 8;

  localparam logic [1:0] REQ_NEW    = 2'd0;
  localparam logic [1:0] REQ_NEXT   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] ST_QUEUED     = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_DISPATCHED = 3'd2;
  localparam logic [2:0] ST_IDLE       = 3'd3;
  localparam logic [2:0] ST_COMPLETED  = 3'd4;
  localparam logic [2:0] ST_NO_CURRENT = 3'd5;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [TrackBitsDef-1:0] track;
    logic [OwnerBitsDef-1:0] process_id;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [TrackBitsDef-1:0] out_track;
    logic [OwnerBitsDef-1:0] out_process_id;
    logic                    direction;
  } out_beat_t;
endpackage
`default_nettype wire

/* src/edrs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module edrs_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/elevator_disk_request_scheduler.sv */
// Elevator (SCAN) disk request scheduler, top level.
// Depends on edrs_pkg and edrs_ram.
// Operation: a request walks its queue from the top down with one RAM read and one write
//   per shifted entry; a dispatch shifts its queue from the bottom up; a finish goes straight out.
// Throughput: one item at a time, set by the single read/write port of each queue RAM.
// Reset: synchronous active low; counts, current request and phase clear, RAM
//   contents are left undefined and never used at or above the count.
`default_nettype none
module elevator_disk_request_scheduler #(
  parameter int QUEUE_DEPTH = edrs_pkg::QueueDepthDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire edrs_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output edrs_pkg::out_beat_t      out_data
);
  localparam int TRACK_BITS = edrs_pkg::TrackBitsDef;
  localparam int OWNER_BITS = edrs_pkg::OwnerBitsDef;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TRACK_BITS + OWNER_BITS;
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1; // read issued, wait
  localparam logic [2:0] S_INS   = 3'd2; // insert walk from top down
  localparam logic [2:0] S_POP   = 3'd3; // pop walk from bottom up
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [CW-1:0] up_cnt_r, dn_cnt_r;
  logic cur_v_r, phase_r, q_r;
  logic [TRACK_BITS-1:0] cur_trk_r, trk_r;
  logic [OWNER_BITS-1:0] cur_own_r, own_r;
  logic ins_r;
  logic [CW-1:0] idx_r; // position being handled
  edrs_pkg::out_beat_t res_r;

  // one RAM per queue; entry = {track, owner}
  logic we_u, we_d;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rd_u, rd_d, rd;
  edrs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_up (
    .clk, .we(we_u), .waddr, .wdata, .raddr, .rdata(rd_u));
  edrs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_dn (
    .clk, .we(we_d), .waddr, .wdata, .raddr, .rdata(rd_d));
  assign rd = q_r ? rd_d : rd_u;

  logic [TRACK_BITS-1:0] rd_trk;
  assign rd_trk = rd[EW-1:OWNER_BITS];
  // insertion: existing entry at idx-1 stays before new one?
  logic stays;
  assign stays = q_r ? (rd_trk >= trk_r) : (rd_trk <= trk_r);

  assign in_ready = (st_r == S_IDLE) && !out_valid;
  logic acc;
  assign acc = in_valid && in_ready;

  logic [TRACK_BITS-1:0] in_trk;
  logic [OWNER_BITS-1:0] in_own;
  assign in_trk = TRACK_BITS'(in_data.track);
  assign in_own = OWNER_BITS'(in_data.process_id);
  logic to_up;
  assign to_up = !cur_v_r || (in_trk > cur_trk_r);
  logic [CW-1:0] in_cnt; // count of the queue a new request targets
  assign in_cnt = to_up ? up_cnt_r : dn_cnt_r;
  logic [CW-1:0] sel_cnt;
  assign sel_cnt = q_r ? dn_cnt_r : up_cnt_r;

  // next-phase decision for dispatch
  logic ph_n;
  always_comb begin
    ph_n = phase_r;
    if (!phase_r && up_cnt_r == '0 && dn_cnt_r != '0) ph_n = 1'b1;
    else if (phase_r && dn_cnt_r == '0 && up_cnt_r != '0) ph_n = 1'b0;
  end
  logic disp_none;
  assign disp_none = (ph_n ? dn_cnt_r : up_cnt_r) == '0;

  always_comb begin
    st_nxt = st_r;
    we_u = 1'b0;
    we_d = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = {trk_r, own_r};
    raddr = '0;
    case (st_r)
      S_RD: begin
        // keep the address so the data is still there next cycle
        if (ins_r) begin
          st_nxt = S_INS;
          raddr = AW'(idx_r - CW'(1));
        end else begin
          st_nxt = S_POP;
          raddr = idx_r[AW-1:0];
        end
      end
      S_INS: begin
        // rd holds entry idx-1
        if (idx_r == '0 || stays) begin
          we_u = !q_r;
          we_d = q_r;
          st_nxt = S_OUT;
        end else begin
          wdata = rd;
          we_u = !q_r;
          we_d = q_r;
          st_nxt = S_RD;
          raddr = AW'(idx_r - CW'(2));
        end
      end
      S_POP: begin
        // rd holds entry idx; move it to idx-1
        waddr = AW'(idx_r - CW'(1));
        wdata = rd;
        if (idx_r + CW'(1) < sel_cnt) begin
          st_nxt = S_RD;
          raddr = AW'(idx_r + CW'(1));
        end else begin
          st_nxt = S_OUT;
        end
        we_u = !q_r && idx_r != '0;
        we_d = q_r && idx_r != '0;
      end
      S_OUT: st_nxt = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          case (in_data.req_type)
            edrs_pkg::REQ_NEW: begin
              raddr = AW'(in_cnt - CW'(1));
              st_nxt = (in_cnt == FULL) ? S_OUT : S_RD;
            end
            edrs_pkg::REQ_NEXT: st_nxt = disp_none ? S_OUT : S_RD; // raddr 0 issued
            edrs_pkg::REQ_FINISH: st_nxt = S_OUT;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      up_cnt_r <= '0;
      dn_cnt_r <= '0;
      cur_v_r <= 1'b0;
      cur_trk_r <= '0;
      cur_own_r <= '0;
      phase_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (acc) begin
            trk_r <= in_trk;
            own_r <= in_own;
            case (in_data.req_type)
              edrs_pkg::REQ_NEW: begin
                q_r <= !to_up;
                ins_r <= 1'b1;
                res_r <= '{status: (in_cnt == FULL) ? edrs_pkg::ST_FULL : edrs_pkg::ST_QUEUED,
                           out_track: 10'(in_trk), out_process_id: 8'(in_own),
                           direction: !to_up};
                if (in_cnt != FULL) begin
                  idx_r <= in_cnt;
                  if (to_up) up_cnt_r <= up_cnt_r + CW'(1);
                  else dn_cnt_r <= dn_cnt_r + CW'(1);
                end
              end
              edrs_pkg::REQ_NEXT: begin
                // both queues empty: idle, phase returns to up
                phase_r <= disp_none ? 1'b0 : ph_n;
                q_r <= ph_n;
                ins_r <= 1'b0;
                idx_r <= '0;
                if (disp_none) begin
                  res_r <= '{status: edrs_pkg::ST_IDLE, default: '0};
                end else begin
                  res_r <= '{status: edrs_pkg::ST_DISPATCHED, out_track: '0,
                             out_process_id: '0, direction: ph_n};
                end
              end
              edrs_pkg::REQ_FINISH: begin
                if (cur_v_r) begin
                  res_r <= '{status: edrs_pkg::ST_COMPLETED, out_track: 10'(cur_trk_r),
                             out_process_id: 8'(cur_own_r), direction: 1'b0};
                  cur_v_r <= 1'b0;
                end else begin
                  res_r <= '{status: edrs_pkg::ST_NO_CURRENT, default: '0};
                end
              end
              default: ;
            endcase
          end
        end
        S_INS: begin
          if (!(idx_r == '0 || stays)) idx_r <= idx_r - CW'(1);
        end
        S_POP: begin
          if (idx_r == '0) begin
            cur_v_r <= 1'b1;
            cur_trk_r <= rd_trk;
            cur_own_r <= rd[OWNER_BITS-1:0];
            res_r.out_track <= 10'(rd_trk);
            res_r.out_process_id <= 8'(rd[OWNER_BITS-1:0]);
          end
          if (idx_r + CW'(1) < sel_cnt) begin
            idx_r <= idx_r + CW'(1);
          end else begin
            if (q_r) dn_cnt_r <= dn_cnt_r - CW'(1);
            else up_cnt_r <= up_cnt_r - CW'(1);
          end
        end
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_data = res_r;

`ifndef SYNTHESIS
  a_up_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    up_cnt_r <= FULL) else $error("up count overflow");
  a_dn_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    dn_cnt_r <= FULL) else $error("down count overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == edrs_pkg::ST_DISPATCHED |-> cur_v_r)
    else $error("dispatch without current");
`endif
endmodule
`default_nettype wire

/* bench/edrs_checker.sv */
// Checker for the elevator disk request scheduler: watches both channels,
// predicts each result with a SCAN queue model and compares. Depends on edrs_pkg.
`default_nettype none
module edrs_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire edrs_pkg::in_beat_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire edrs_pkg::out_beat_t out_data,
  output int                       fail_count,
  output int                       pending
);
  localparam int Depth = edrs_pkg::QueueDepthDef;

  typedef struct packed {
    logic [9:0] trk;
    logic [7:0] pid;
  } slot_t;

  slot_t               up_q[$];
  slot_t               down_q[$];
  logic                cur_valid;
  slot_t               cur;
  logic                phase_down;
  edrs_pkg::out_beat_t want_q[$];

  function automatic edrs_pkg::out_beat_t mk(logic [2:0] st, logic [9:0] t, logic [7:0] p,
                                             logic d);
    edrs_pkg::out_beat_t r;
    r.status = st;
    r.out_track = t;
    r.out_process_id = p;
    r.direction = d;
    return r;
  endfunction

  // Sorted insert, stable after equal tracks.
  task automatic sorted_insert(input logic descending, input slot_t s);
    int pos;
    pos = 0;
    if (descending) begin
      while (pos < down_q.size() && !(down_q[pos].trk < s.trk)) pos++;
      down_q.insert(pos, s);
    end else begin
      while (pos < up_q.size() && !(up_q[pos].trk > s.trk)) pos++;
      up_q.insert(pos, s);
    end
  endtask

  task automatic schedule(input edrs_pkg::in_beat_t b);
    logic  to_up;
    slot_t s;
    s.trk = b.track;
    s.pid = b.process_id;
    case (b.req_type)
      edrs_pkg::REQ_NEW: begin
        to_up = !cur_valid || (b.track > cur.trk);
        if ((to_up ? up_q.size() : down_q.size()) >= Depth) begin
          want_q.push_back(mk(edrs_pkg::ST_FULL, b.track, b.process_id, !to_up));
        end else begin
          sorted_insert(!to_up, s);
          want_q.push_back(mk(edrs_pkg::ST_QUEUED, b.track, b.process_id, !to_up));
        end
      end
      edrs_pkg::REQ_NEXT: begin
        if (!phase_down && up_q.size() == 0 && down_q.size() != 0) phase_down = 1'b1;
        else if (phase_down && down_q.size() == 0 && up_q.size() != 0) phase_down = 1'b0;
        if (!phase_down && up_q.size() != 0) begin
          cur = up_q.pop_front();
          cur_valid = 1'b1;
          want_q.push_back(mk(edrs_pkg::ST_DISPATCHED, cur.trk, cur.pid, 1'b0));
        end else if (phase_down && down_q.size() != 0) begin
          cur = down_q.pop_front();
          cur_valid = 1'b1;
          want_q.push_back(mk(edrs_pkg::ST_DISPATCHED, cur.trk, cur.pid, 1'b1));
        end else begin
          phase_down = 1'b0;
          want_q.push_back(mk(edrs_pkg::ST_IDLE, '0, '0, 1'b0));
        end
      end
      edrs_pkg::REQ_FINISH: begin
        if (cur_valid) begin
          want_q.push_back(mk(edrs_pkg::ST_COMPLETED, cur.trk, cur.pid, 1'b0));
          cur_valid = 1'b0;
        end else begin
          want_q.push_back(mk(edrs_pkg::ST_NO_CURRENT, '0, '0, 1'b0));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    edrs_pkg::out_beat_t w;
    if (!rst_n) begin
      up_q.delete();
      down_q.delete();
      want_q.delete();
      cur_valid = 1'b0;
      cur = '0;
      phase_down = 1'b0;
      fail_count = 0;
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          if (w.status !== out_data.status)
            $display("%0t: status expected %0d actual %0d", $time, w.status, out_data.status);
          if (w.out_track !== out_data.out_track)
            $display("%0t: track expected %0d actual %0d", $time, w.out_track,
                     out_data.out_track);
          if (w.out_process_id !== out_data.out_process_id)
            $display("%0t: process id expected %0d actual %0d", $time, w.out_process_id,
                     out_data.out_process_id);
          if (w.direction !== out_data.direction)
            $display("%0t: direction expected %0d actual %0d", $time, w.direction,
                     out_data.direction);
          if (w !== out_data) fail_count++;
        end
      end
      // Predict after the compare so a same-edge result never pops its own beat.
      if (in_valid && in_ready) schedule(in_data);
      pending = want_q.size();
    end
  end
endmodule
`default_nettype wire

/* bench/elevator_disk_request_scheduler_test.sv */
// Top of the scheduler bench: clock, reset, stimulus and verdict.
// Depends on edrs_pkg, elevator_disk_request_scheduler and edrs_checker.
`default_nettype none
module elevator_disk_request_scheduler_test;
  localparam int CycleLimit = 2000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  edrs_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  edrs_pkg::out_beat_t out_data;
  int                  fail_count;
  int                  pending;

  // Receiver modes: 0 random stalls, 1 always ready, 2 long hold-off.
  int        sink_mode = 0;
  int        cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  elevator_disk_request_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  edrs_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Watchdog: any hang ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("elevator_disk_request_scheduler verification failed");
      $finish;
    end
  end

  // Receiver: ready decided fresh every edge.
  always @(posedge clk) begin
    case (sink_mode)
      1:       out_ready <= 1'b1;
      2:       out_ready <= 1'b0;
      default: out_ready <= ($urandom_range(99) >= 33);
    endcase
  end

  // Offer one beat, hold it until taken; optional idle cycles first.
  task automatic send(input logic [1:0] kind, input logic [9:0] t, input logic [7:0] p,
                      input bit gaps);
    edrs_pkg::in_beat_t b;
    b.req_type = kind;
    b.track = t;
    b.process_id = p;
    while (gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_beat(input bit gaps);
    int r;
    logic [9:0] t;
    r = $urandom_range(99);
    t = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                 : 10'($urandom_range(1023)) & 10'h3f3;
    if (r < 50) send(edrs_pkg::REQ_NEW, t, 8'($urandom_range(255)), gaps);
    else if (r < 78)
      send(edrs_pkg::REQ_NEXT, 10'($urandom_range(1023)), 8'($urandom_range(255)), gaps);
    else if (r < 96)
      send(edrs_pkg::REQ_FINISH, 10'($urandom_range(1023)), 8'($urandom_range(255)), gaps);
    else
      send(edrs_pkg::REQ_UNUSED, 10'($urandom_range(1023)), 8'($urandom_range(255)), gaps);
  endtask

  initial begin
    int hold;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-state cases, ties, both queues, phase switches, extremes.
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);       // idle on empty queues
    send(edrs_pkg::REQ_FINISH, 10'd0, 8'd0, 1'b0);     // finish with nothing current
    send(edrs_pkg::REQ_NEW, 10'd1023, 8'd255, 1'b0);
    send(edrs_pkg::REQ_NEW, 10'd0, 8'd0, 1'b0);
    send(edrs_pkg::REQ_NEW, 10'd500, 8'd1, 1'b0);
    send(edrs_pkg::REQ_NEW, 10'd500, 8'd2, 1'b0);      // tie lands after equal track
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);       // current = track 0
    send(edrs_pkg::REQ_NEW, 10'd0, 8'd9, 1'b0);        // equal to current: down queue
    send(edrs_pkg::REQ_NEW, 10'd300, 8'd10, 1'b0);
    send(edrs_pkg::REQ_UNUSED, 10'd1023, 8'd255, 1'b0); // unused type, no result
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);       // replaces current silently
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);
    send(edrs_pkg::REQ_NEW, 10'd200, 8'd11, 1'b0);     // below current: down queue
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);       // last up entry, track 1023; the next one switches to down phase
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);
    send(edrs_pkg::REQ_FINISH, 10'd0, 8'd0, 1'b0);     // completed
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);       // idle, phase back to up
    send(edrs_pkg::REQ_FINISH, 10'd0, 8'd0, 1'b0);
    go_quiet();

    // Fill the up queue past full with no current request.
    for (k = 0; k < 34; k++)
      send(edrs_pkg::REQ_NEW, 10'($urandom_range(1023)), 8'($urandom_range(255)), 1'b1);
    // Dispatch one, then overfill the down queue with low tracks.
    send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b0);
    for (k = 0; k < 40; k++) send(edrs_pkg::REQ_NEW, 10'd0, 8'($urandom_range(255)), 1'b1);
    for (k = 0; k < 70; k++) send(edrs_pkg::REQ_NEXT, 10'd0, 8'd0, 1'b1);
    go_quiet();

    // Long receiver hold-off while beats keep coming.
    fork
      begin
        sink_mode = 2;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
        sink_mode = 0;
      end
      for (k = 0; k < 30; k++) random_beat(1'b0);
    join
    go_quiet();

    // Main random run; a middle stretch with no idling on either side.
    for (k = 0; k < 1300; k++) begin
      sink_mode = (k >= 500 && k < 700) ? 1 : 0;
      random_beat(!(k >= 500 && k < 700));
      if (k % 300 == 299) go_quiet();                 // sender waits for every result
    end
    sink_mode = 0;
    go_quiet();

    if (fail_count == 0) begin
      $display("elevator_disk_request_scheduler verification clean");
    end else begin
      $display("elevator_disk_request_scheduler verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
